// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication into the next cycle, off while reset is active
`define AVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// same-cycle implication, off while reset is active
`define AVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// checked at every edge, reset included
`define AVM_ASSERT_ALWAYS(label, clk, expr) \
    label: assert property (@(posedge clk) (expr)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/avm_pkg.sv -----
package avm_pkg;

    localparam int IN_W       = 48;
    localparam int OUT_W      = 24;
    localparam int MAG_W      = 17;
    localparam int RAW_W      = 14;
    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 35;
    localparam int SUM_W      = 32;
    localparam int DIVS_W     = SUM_W + 1;
    localparam int SCALE_MUL  = 9810;
    localparam int SCALE_SHIFT = 10;
    localparam int STEP_LIMIT = 64;
    localparam int STEP_W     = $clog2(STEP_LIMIT);
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [SUM_W-1:0] sum;
    } front_res_t;

endpackage

// ----- rtl/core/avm_div.sv -----
module avm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [avm_pkg::SUM_W-1:0]  dividend,
    input  logic [avm_pkg::DIVS_W-1:0] divisor,
    output logic                       done,
    output logic [avm_pkg::SUM_W-1:0]  quotient
);
    import avm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [DIVS_W-1:0]    dsr_reg;
    logic [DIVS_W:0]      shifted;
    logic [DIVS_W:0]      trial;
    logic                 fits;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DIVS_W-1:0] : shifted[DIVS_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/avm_front.sv -----
module avm_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [avm_pkg::IN_W-1:0] data,
    output avm_pkg::front_res_t      res
);
    import avm_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SCALE  = 2'd1;
    localparam logic [1:0] PH_SQUARE = 2'd2;
    localparam logic [1:0] PH_ACC    = 2'd3;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [AXIS_W-1:0] axis_reg;
    logic              done_reg;
    logic [RAW_W-1:0]  raw_reg [AXES];
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic [RAW_W-1:0]  cur;
    logic [RAW_W-1:0]  cur_abs;
    logic [MUL_W-1:0]  mm;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              last_axis;

    // truncation toward zero on the scaled value: work on the magnitude, the sign drops out
    assign cur       = raw_reg[axis_reg];
    assign cur_abs   = cur[RAW_W-1] ? RAW_W'(~cur + RAW_W'(1)) : cur;
    assign mm        = prod_reg[SCALE_SHIFT +: MUL_W];
    assign last_axis = axis_reg == AXIS_W'(AXES - 1);

    // one shared multiplier: scale step, then square step
    always_comb
    begin
        if (phase_reg == PH_SCALE)
        begin
            mul_a = MUL_W'(cur_abs);
            mul_b = MUL_W'(SCALE_MUL);
        end
        else
        begin
            mul_a = mm;
            mul_b = mm;
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:   phase_next = start ? PH_SCALE : PH_IDLE;
            PH_SCALE:  phase_next = PH_SQUARE;
            PH_SQUARE: phase_next = PH_ACC;
            PH_ACC:    phase_next = last_axis ? PH_IDLE : PH_SCALE;
            default:   phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            axis_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_ACC) && last_axis;
            if (phase_reg == PH_IDLE)
            begin
                axis_reg <= '0;
            end
            else if (phase_reg == PH_ACC)
            begin
                axis_reg <= axis_reg + AXIS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            raw_reg[0] <= {data[7:0],   data[15:10]};
            raw_reg[1] <= {data[23:16], data[31:26]};
            raw_reg[2] <= {data[39:32], data[47:42]};
            acc_reg    <= '0;
        end
        else if (phase_reg == PH_ACC)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (phase_reg == PH_SCALE || phase_reg == PH_SQUARE)
        begin
            prod_reg <= mul_p;
        end
    end

    // clamp to 32 bits
    assign res.done = done_reg;
    assign res.sat  = acc_reg[ACC_W-1:SUM_W] != '0;
    assign res.sum  = res.sat ? '1 : acc_reg[SUM_W-1:0];

endmodule

// ----- rtl/core/accel_vector_magnitude_core.sv -----
// Three-axis acceleration magnitude in mm/s^2 from six raw sensor bytes per request. Each
// request scales and squares the three axes on one shared multiplier, then runs Newton steps
// on the 32-bit serial divider that yields one quotient bit a cycle; full-scale inputs need
// fewer than 20 steps, and sums of 0 or 1 skip the loop. s_axis_tready is high only while the
// core is idle; a finished result waits in the output register, so the next request can be
// taken while it is still unread.
module accel_vector_magnitude_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // x_high, x_low, y_high, y_low, z_high, z_low
    input  logic [avm_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // magnitude, zero pad
    output logic [avm_pkg::OUT_W-1:0] m_axis_tdata,
    // sum_saturated
    output logic                      m_axis_tuser
);
    import avm_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_FRONT     = 3'd1;
    localparam logic [2:0] ST_DIV_START = 3'd2;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd3;
    localparam logic [2:0] ST_FINISH    = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              sat_reg;
    logic [SUM_W-1:0]  root_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  out_mag_reg;
    logic              out_sat_reg;

    front_res_t        front_res;
    logic              in_fire;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;
    logic              small_sum;
    logic [SUM_W-1:0]  guess_raw;
    logic [SUM_W-1:0]  guess;
    logic [SUM_W:0]    new_wide;
    logic [SUM_W-1:0]  new_root;
    logic [SUM_W:0]    delta;
    logic              converged;
    logic              last_step;
    logic              out_load;

    assign s_axis_tready = state_reg == ST_IDLE;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    avm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .data  (s_axis_tdata),
        .res   (front_res)
    );

    avm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV_START),
        .dividend (sum_reg),
        .divisor  ({root_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_quo)
    );

    // first guess sum/8, at least 1
    assign small_sum = front_res.sum[SUM_W-1:1] == '0;
    assign guess_raw = {3'b000, front_res.sum[SUM_W-1:3]};
    assign guess     = (guess_raw == '0) ? SUM_W'(1) : guess_raw;

    // root/2 + sum/(2*root), at least 1
    assign new_wide  = {2'b00, root_reg[SUM_W-1:1]} + {1'b0, div_quo};
    assign new_root  = (new_wide[SUM_W-1:0] == '0) ? SUM_W'(1) : new_wide[SUM_W-1:0];
    assign delta     = {1'b0, new_root} - {1'b0, root_reg};
    assign converged = (delta == '0) || (delta == (SUM_W + 1)'(1)) || (delta == '1);
    assign last_step = step_reg == STEP_W'(STEP_LIMIT - 1);

    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_FRONT;
                end
            end
            ST_FRONT:
            begin
                if (front_res.done)
                begin
                    state_next = small_sum ? ST_FINISH : ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (converged || last_step) ? ST_FINISH : ST_DIV_START;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FRONT)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_DIV_WAIT && div_done)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FRONT && front_res.done)
        begin
            sum_reg  <= front_res.sum;
            sat_reg  <= front_res.sat;
            root_reg <= guess;
            mag_reg  <= front_res.sum[MAG_W-1:0];
        end
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            root_reg <= new_root;
            mag_reg  <= new_root[MAG_W-1:0] + MAG_W'(1);
        end
        if (out_load)
        begin
            out_mag_reg <= mag_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_mag_reg);
    assign m_axis_tuser  = out_sat_reg;

endmodule

// ----- rtl/core/avm_checker.sv -----
`include "assert_macros.svh"

module avm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [avm_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [avm_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tuser
);
    import avm_pkg::*;

    logic in_fire;
    logic out_stall;
    logic unused_data;

    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign unused_data = ^s_axis_tdata;

    // one request at a time: busy right after a request is taken
    `AVM_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_fire, !s_axis_tready)

    // the output stays empty just after a request is taken on an empty output
    `AVM_ASSERT_NEXT(a_no_instant_result, clk, rst_n,
        in_fire && !m_axis_tvalid, !m_axis_tvalid)

    // pad bits above the magnitude stay zero
    `AVM_ASSERT_NOW(a_pad_zero, clk, rst_n,
        m_axis_tvalid || unused_data, m_axis_tdata[OUT_W-1:MAG_W] == '0)

    // a stalled result holds
    `AVM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // nothing offered while reset is held
    `AVM_ASSERT_ALWAYS(a_reset_quiet, clk, rst_n || !m_axis_tvalid)

endmodule

bind accel_vector_magnitude_core avm_checker u_avm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/accel_vector_magnitude_core_test.sv -----
module accel_vector_magnitude_core_test;
    import avm_pkg::*;

    localparam int RANDOM_REQUESTS = 580;

    typedef struct {
        logic [MAG_W-1:0] magnitude;
        logic             sat;
    } magnitude_t;

    class magnitude_scoreboard;
        magnitude_t pending_q[$];
        int         errors;
        int         requests;
        int         saturated;
        int         results;

        function new();
            errors    = 0;
            requests  = 0;
            saturated = 0;
            results   = 0;
        endfunction

        function longint scale_axis(logic [7:0] hi, logic [7:0] lo);
            logic signed [RAW_W-1:0] raw;
            longint                  prod;
            raw  = {hi, lo[7:2]};
            prod = longint'(raw) * SCALE_MUL;
            // signed division truncates toward zero
            return prod / (1 << SCALE_SHIFT);
        endfunction

        function longint unsigned newton_magnitude(longint unsigned s);
            longint unsigned root;
            longint unsigned prev;
            longint unsigned delta;
            if (s <= 1)
            begin
                return s;
            end
            root = s / 8;
            if (root == 0)
            begin
                root = 1;
            end
            for (int k = 0; k < STEP_LIMIT; k++)
            begin
                prev = root;
                root = root / 2 + s / (2 * root);
                if (root == 0)
                begin
                    root = 1;
                end
                delta = (root > prev) ? root - prev : prev - root;
                if (delta <= 1)
                begin
                    break;
                end
            end
            return root + 1;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void note_request(logic [IN_W-1:0] data);
            longint          x;
            longint          y;
            longint          z;
            longint unsigned sum;
            magnitude_t      e;
            x   = scale_axis(data[7:0], data[15:8]);
            y   = scale_axis(data[23:16], data[31:24]);
            z   = scale_axis(data[39:32], data[47:40]);
            sum = x * x + y * y + z * z;
            e.sat = (sum > 64'h0000_0000_FFFF_FFFF);
            if (e.sat)
            begin
                sum = 64'h0000_0000_FFFF_FFFF;
            end
            e.magnitude = MAG_W'(newton_magnitude(sum));
            pending_q.push_back(e);
            requests++;
            if (e.sat)
            begin
                saturated++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic user);
            magnitude_t e;
            results++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with no request pending, magnitude %0d sat %0b",
                         $time, data[MAG_W-1:0], user);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (data[MAG_W-1:0] !== e.magnitude)
            begin
                $display("%0t: magnitude mismatch, expected %0d actual %0d",
                         $time, e.magnitude, data[MAG_W-1:0]);
                errors++;
            end
            if (user !== e.sat)
            begin
                $display("%0t: sum_saturated mismatch, expected %0b actual %0b",
                         $time, e.sat, user);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;

    logic                idle_on;
    int                  rx_stall = 0;
    magnitude_scoreboard board;

    accel_vector_magnitude_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // samples are 14-bit two's complement; junk lands in the unused low bits
    function automatic logic [IN_W-1:0] pack_samples(int sx, int sy, int sz, logic [1:0] junk);
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        logic [RAW_W-1:0] rz;
        rx = sx[RAW_W-1:0];
        ry = sy[RAW_W-1:0];
        rz = sz[RAW_W-1:0];
        return {rz[5:0], junk, rz[13:6], ry[5:0], junk, ry[13:6], rx[5:0], junk, rx[13:6]};
    endfunction

    function automatic int small_sample();
        return int'($urandom_range(0, 256)) - 128;
    endfunction

    function automatic int wide_sample(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_request(logic [IN_W-1:0] data);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(data);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                board.check_result(m_axis_tdata, m_axis_tuser);
            end
            if (rx_stall > 0)
            begin
                rx_stall      <= rx_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rx_stall      <= $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [IN_W-1:0] directed_q[$];
        logic [IN_W-1:0] data;
        int              sx;
        int              sy;
        int              sz;

        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_on       = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_q.push_back(pack_samples(0, 0, 0, 2'b00));
        // ignored low bits set, sum stays zero
        directed_q.push_back(pack_samples(0, 0, 0, 2'b11));
        directed_q.push_back(pack_samples(1, 0, 0, 2'b01));
        directed_q.push_back(pack_samples(-1, -1, -1, 2'b10));
        directed_q.push_back(pack_samples(8191, 0, 0, 2'b00));
        directed_q.push_back(pack_samples(0, -8192, 0, 2'b11));
        directed_q.push_back(pack_samples(0, 0, 8191, 2'b00));
        directed_q.push_back(pack_samples(-8192, 0, 0, 2'b00));
        directed_q.push_back(pack_samples(8191, 8191, 8191, 2'b11));
        directed_q.push_back(pack_samples(-8192, -8192, -8192, 2'b00));
        // single axis just below and just above saturation
        directed_q.push_back(pack_samples(6840, 0, 0, 2'b00));
        directed_q.push_back(pack_samples(6841, 0, 0, 2'b00));
        directed_q.push_back(pack_samples(0, 0, -6841, 2'b01));
        directed_q.push_back(pack_samples(0, -6840, 0, 2'b10));
        directed_q.push_back(pack_samples(4000, -4000, 4000, 2'b00));
        directed_q.push_back(pack_samples(100, -100, 1, 2'b00));
        directed_q.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        directed_q.push_back({8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
        foreach (directed_q[i])
        begin
            send_request(directed_q[i]);
        end

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            idle_on <= !((i >= 200 && i < 300) || i >= RANDOM_REQUESTS - 80);
            if (i == 300)
            begin
                // drain the core completely before going on
                s_axis_tvalid <= 1'b0;
                do @(posedge clk); while (board.pending() != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    data = IN_W'({$urandom, $urandom});
                end
                3, 4:
                begin
                    data = pack_samples(small_sample(), small_sample(), small_sample(),
                                        2'($urandom));
                end
                5, 6:
                begin
                    sx = 6830 + int'($urandom_range(0, 20));
                    if ($urandom_range(0, 1))
                    begin
                        sx = -sx;
                    end
                    sy = small_sample();
                    sz = small_sample();
                    case ($urandom_range(0, 2))
                        0: data = pack_samples(sx, sy, sz, 2'($urandom));
                        1: data = pack_samples(sy, sx, sz, 2'($urandom));
                        default: data = pack_samples(sy, sz, sx, 2'($urandom));
                    endcase
                end
                default:
                begin
                    data = pack_samples(wide_sample(4000), wide_sample(4000),
                                        wide_sample(4000), 2'($urandom));
                end
            endcase
            send_request(data);
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (800) @(posedge clk);

        $display("%0d requests with %0d saturated sums; %0d results checked, %0d mismatches",
                 board.requests, board.saturated, board.results, board.errors);
        if (board.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", board.pending());
        $display("Verification failed");
        $finish;
    end

endmodule
